// ----- hdl/cce_pkg.sv -----
// shared types and constants for the canonical code encoder
// no dependencies; imported by cce_table, canonical_huffman_encoder_top and the bench

package cce_pkg;

    localparam int MAX_CODE_LEN_DEF = 32;
    localparam int NUM_SYMBOLS_DEF  = 128;

    localparam int KIND_W = 2;
    localparam int SYM_W  = 7;
    localparam int LEN_W  = 6;
    localparam int BYTE_W = 8;

    localparam logic [SYM_W-1:0] END_SYMBOL_RST = 7'd3;

    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD   = 2'd0,
        KIND_ENCODE = 2'd1,
        KIND_END    = 2'd2
    } kind_t;

    // table control from the sequencer
    typedef struct packed {
        logic wr;
        logic clr_marks;
    } tbl_ctrl_t;

endpackage

// ----- hdl/cce_table.sv -----
// code table: left-aligned code words and lengths in a memory, plus present marks
// depends on cce_pkg

module cce_table #(
    parameter int MAX_CODE_LEN = cce_pkg::MAX_CODE_LEN_DEF,
    parameter int NUM_SYMBOLS  = cce_pkg::NUM_SYMBOLS_DEF,
    parameter int IDX_W        = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1,
    parameter int CNT_W        = $clog2(MAX_CODE_LEN + 1)
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  cce_pkg::tbl_ctrl_t      ctrl,
    input  logic [IDX_W-1:0]        waddr,
    input  logic [MAX_CODE_LEN-1:0] wcode,
    input  logic [CNT_W-1:0]        wlen,
    input  logic [IDX_W-1:0]        raddr,
    output logic [MAX_CODE_LEN-1:0] rcode,
    output logic [CNT_W-1:0]        rlen,
    output logic                    present
);
    import cce_pkg::*;

    localparam int ENTRY_W = MAX_CODE_LEN + CNT_W;

    logic [ENTRY_W-1:0]     mem [NUM_SYMBOLS];
    logic [ENTRY_W-1:0]     rdata_reg;
    logic [NUM_SYMBOLS-1:0] marks_reg;
    logic                   raddr_ok;

    always_ff @(posedge clk)
    begin
        if (ctrl.wr)
        begin
            mem[waddr] <= {wcode, wlen};
        end
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            marks_reg <= '0;
        end
        else
        begin
            if (ctrl.clr_marks)
            begin
                marks_reg <= '0;
            end
            if (ctrl.wr)
            begin
                marks_reg[waddr] <= 1'b1;
            end
        end
    end

    assign raddr_ok = ({1'b0, raddr} < (IDX_W+1)'(NUM_SYMBOLS));
    assign present  = raddr_ok ? marks_reg[raddr] : 1'b0;
    assign rcode    = rdata_reg[ENTRY_W-1:CNT_W];
    assign rlen     = rdata_reg[CNT_W-1:0];

endmodule

// ----- hdl/canonical_huffman_encoder_top.sv -----
// canonical prefix-code encoder with byte packing, top level
// depends on cce_pkg and cce_table
//
//  channel   | handshake                  | payload
//  ----------+----------------------------+---------------------------------------
//  request   | start / busy               | kind, symbol, code_length, table_start
//  result    | valid (one-cycle strobe)   | out_byte, is_last, error
//  config    | end_symbol_we              | end_symbol_data
//
// one shared shifter (up to 8 bits a cycle) does all the work under a small sequencer.
// load: the next code is shifted left by the length growth, then left-aligned and written.
// encode/end: the code is fetched, then shifted out in chunks of up to a byte;
// an unmapped symbol gives an error byte with no fetch. busy is high while a request is being worked on.
// reset clears the present marks, the bit buffer and the code counter at once.
// results cannot be stalled; at most one byte leaves per cycle.

module canonical_huffman_encoder_top #(
    parameter int MAX_CODE_LEN = cce_pkg::MAX_CODE_LEN_DEF,
    parameter int NUM_SYMBOLS  = cce_pkg::NUM_SYMBOLS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [cce_pkg::KIND_W-1:0]   kind,
    input  logic [cce_pkg::SYM_W-1:0]    symbol,
    input  logic [cce_pkg::LEN_W-1:0]    code_length,
    input  logic                         table_start,
    input  logic                         end_symbol_we,
    input  logic [cce_pkg::SYM_W-1:0]    end_symbol_data,
    output logic                         valid,
    output logic [cce_pkg::BYTE_W-1:0]   out_byte,
    output logic                         is_last,
    output logic                         error
);
    import cce_pkg::*;

    localparam int IDX_W = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
    localparam int CNT_W = $clog2(MAX_CODE_LEN + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_GROW,
        S_ALIGN,
        S_FETCH,
        S_ENC
    } state_t;

    state_t                  state_reg, state_next;
    logic [MAX_CODE_LEN-1:0] work_reg, work_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [MAX_CODE_LEN-1:0] prev_code_reg, prev_code_next;
    logic [CNT_W-1:0]        prev_len_reg, prev_len_next;
    logic [CNT_W-1:0]        len_reg, len_next;
    logic [IDX_W-1:0]        sym_reg, sym_next;
    logic                    first_reg, first_next;
    logic [6:0]              pend_reg, pend_next;
    logic [2:0]              pcnt_reg, pcnt_next;
    logic                    end_reg, end_next;
    logic [SYM_W-1:0]        end_symbol_reg;
    logic                    valid_reg, valid_next;
    logic [BYTE_W-1:0]       byte_reg, byte_next;
    logic                    last_reg, last_next;
    logic                    err_reg, err_next;

    tbl_ctrl_t               tbl_ctrl;
    logic [IDX_W-1:0]        raddr;
    logic [MAX_CODE_LEN-1:0] rcode;
    logic [CNT_W-1:0]        rlen;
    logic                    present;

    // lookup symbol and range checks
    logic [SYM_W-1:0]        look_sym;
    logic [8:0]              look_ext;
    logic                    look_ok;
    logic [8:0]              load_ext;
    logic                    load_ok;
    logic [CNT_W-1:0]        len_sat;
    logic [CNT_W-1:0]        grow;
    logic                    first_eff;

    // shared shift unit
    logic [3:0]              lim;
    logic [3:0]              amt;
    logic [MAX_CODE_LEN-1:0] work_shift;
    logic [BYTE_W-1:0]       top8;
    logic [15:0]             merge;
    logic [BYTE_W-1:0]       newval;
    logic [3:0]              pc_sum;
    logic [CNT_W-1:0]        rem_after;
    logic                    fin;
    logic                    emit;
    logic [BYTE_W-1:0]       padded;

    cce_table #(
        .MAX_CODE_LEN (MAX_CODE_LEN),
        .NUM_SYMBOLS  (NUM_SYMBOLS),
        .IDX_W        (IDX_W),
        .CNT_W        (CNT_W)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (tbl_ctrl),
        .waddr   (sym_reg),
        .wcode   (work_reg),
        .wlen    (len_reg),
        .raddr   (raddr),
        .rcode   (rcode),
        .rlen    (rlen),
        .present (present)
    );

    assign look_sym = (kind_t'(kind) == KIND_ENCODE) ? symbol : end_symbol_reg;
    assign look_ext = {2'b0, look_sym};
    assign look_ok  = (look_ext < 9'(NUM_SYMBOLS));
    assign raddr    = look_ext[IDX_W-1:0];

    assign load_ext  = {2'b0, symbol};
    assign load_ok   = (load_ext < 9'(NUM_SYMBOLS));
    assign len_sat   = ({1'b0, code_length} > 7'(MAX_CODE_LEN)) ?
                       CNT_W'(MAX_CODE_LEN) : CNT_W'(code_length);
    assign grow      = (len_sat > prev_len_reg) ? (len_sat - prev_len_reg) : '0;
    assign first_eff = first_reg | table_start;

    // while encoding the step is limited by the room left in the byte
    assign lim        = (state_reg == S_ENC) ? (4'd8 - {1'b0, pcnt_reg}) : 4'd8;
    assign amt        = (cnt_reg < CNT_W'(lim)) ? cnt_reg[3:0] : lim;
    assign work_shift = work_reg << amt;
    assign top8       = work_reg[MAX_CODE_LEN-1 -: BYTE_W];
    assign merge      = {1'b0, pend_reg, top8} << amt;
    assign newval     = merge[15:8];
    assign pc_sum     = {1'b0, pcnt_reg} + amt;
    assign rem_after  = cnt_reg - CNT_W'(amt);
    assign fin        = end_reg && (rem_after == '0);
    assign emit       = (pc_sum == 4'd8) || (fin && (pc_sum != 4'd0));
    assign padded     = newval << (4'd8 - pc_sum);

    assign tbl_ctrl.wr        = (state_reg == S_ALIGN) && (cnt_reg == '0);
    assign tbl_ctrl.clr_marks = (state_reg == S_IDLE) && start &&
                                (kind_t'(kind) == KIND_LOAD) && table_start;

    always_comb
    begin
        state_next     = state_reg;
        work_next      = work_reg;
        cnt_next       = cnt_reg;
        prev_code_next = prev_code_reg;
        prev_len_next  = prev_len_reg;
        len_next       = len_reg;
        sym_next       = sym_reg;
        first_next     = first_reg;
        pend_next      = pend_reg;
        pcnt_next      = pcnt_reg;
        end_next       = end_reg;
        valid_next     = 1'b0;
        byte_next      = byte_reg;
        last_next      = 1'b0;
        err_next       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (kind_t'(kind))
                        KIND_LOAD:
                        begin
                            if (table_start)
                            begin
                                pend_next  = '0;
                                pcnt_next  = '0;
                                first_next = 1'b1;
                            end
                            if (load_ok)
                            begin
                                first_next = 1'b0;
                                sym_next   = load_ext[IDX_W-1:0];
                                len_next   = len_sat;
                                if (first_eff)
                                begin
                                    work_next = '0;
                                    cnt_next  = '0;
                                end
                                else
                                begin
                                    work_next = prev_code_reg + MAX_CODE_LEN'(1);
                                    cnt_next  = grow;
                                end
                                state_next = S_GROW;
                            end
                        end
                        KIND_ENCODE, KIND_END:
                        begin
                            end_next = (kind_t'(kind) == KIND_END);
                            if (look_ok && present)
                            begin
                                state_next = S_FETCH;
                            end
                            else
                            begin
                                valid_next = 1'b1;
                                byte_next  = '0;
                                err_next   = 1'b1;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_GROW:
            begin
                if (cnt_reg == '0)
                begin
                    prev_code_next = work_reg;
                    prev_len_next  = len_reg;
                    cnt_next       = CNT_W'(MAX_CODE_LEN) - len_reg;
                    state_next     = S_ALIGN;
                end
                else
                begin
                    work_next = work_shift;
                    cnt_next  = rem_after;
                end
            end
            S_ALIGN:
            begin
                // code is left-aligned in the word before it is stored
                if (cnt_reg == '0)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    work_next = work_shift;
                    cnt_next  = rem_after;
                end
            end
            S_FETCH:
            begin
                work_next  = rcode;
                cnt_next   = rlen;
                state_next = S_ENC;
            end
            S_ENC:
            begin
                work_next = work_shift;
                cnt_next  = rem_after;
                if (emit)
                begin
                    valid_next = 1'b1;
                    byte_next  = padded;
                    last_next  = fin;
                    pend_next  = '0;
                    pcnt_next  = '0;
                end
                else
                begin
                    pend_next = newval[6:0];
                    pcnt_next = pc_sum[2:0];
                end
                if (rem_after == '0)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            prev_code_reg  <= '0;
            prev_len_reg   <= '0;
            first_reg      <= 1'b1;
            pend_reg       <= '0;
            pcnt_reg       <= '0;
            end_reg        <= 1'b0;
            end_symbol_reg <= END_SYMBOL_RST;
            valid_reg      <= 1'b0;
            last_reg       <= 1'b0;
            err_reg        <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            prev_code_reg <= prev_code_next;
            prev_len_reg  <= prev_len_next;
            first_reg     <= first_next;
            pend_reg      <= pend_next;
            pcnt_reg      <= pcnt_next;
            end_reg       <= end_next;
            valid_reg     <= valid_next;
            last_reg      <= last_next;
            err_reg       <= err_next;
            if (end_symbol_we)
            begin
                end_symbol_reg <= end_symbol_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        len_reg  <= len_next;
        sym_reg  <= sym_next;
        byte_reg <= byte_next;
    end

    assign busy     = (state_reg != S_IDLE);
    assign valid    = valid_reg;
    assign out_byte = byte_reg;
    assign is_last  = last_reg;
    assign error    = err_reg;

endmodule

// ----- bench/tb.sv -----
// self-checking bench for canonical_huffman_encoder_top: directed tables, then random streams
// keeps its own code table and bit packer to predict every output byte
// depends on cce_pkg and canonical_huffman_encoder_top

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cce_pkg::*;

    localparam int CODE_LEN_MAX  = MAX_CODE_LEN_DEF;
    localparam int SYMBOL_COUNT  = NUM_SYMBOLS_DEF;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 24;
    localparam int STALL_LIMIT   = 4000;
    localparam int RANDOM_ITEMS  = 280;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
        logic              err;
    } packed_byte_t;

    logic                 clk             = 1'b0;
    logic                 rst_n           = 1'b0;
    logic                 start           = 1'b0;
    logic [KIND_W-1:0]    kind            = '0;
    logic [SYM_W-1:0]     symbol          = '0;
    logic [LEN_W-1:0]     code_length     = '0;
    logic                 table_start     = 1'b0;
    logic                 end_symbol_we   = 1'b0;
    logic [SYM_W-1:0]     end_symbol_data = END_SYMBOL_RST;
    logic                 busy;
    logic                 valid;
    logic [BYTE_W-1:0]    out_byte;
    logic                 is_last;
    logic                 error;

    // predicted encoder state
    logic [CODE_LEN_MAX-1:0] code_word [SYMBOL_COUNT];
    logic [LEN_W-1:0]        code_len  [SYMBOL_COUNT];
    bit                      present   [SYMBOL_COUNT];
    logic [CODE_LEN_MAX-1:0] prev_code_word = '0;
    logic [LEN_W-1:0]        last_len   = '0;
    bit                      first_entry = 1'b1;
    logic [BYTE_W-1:0]       acc_bits   = '0;
    int                      acc_count  = 0;
    logic [SYM_W-1:0]        end_sym    = END_SYMBOL_RST;

    packed_byte_t     expected_bytes [$];
    logic [SYM_W-1:0] tbl_syms [$];
    int               err_count  = 0;
    int               sent_items = 0;
    bit               no_gaps    = 1'b0;

    canonical_huffman_encoder_top u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .kind            (kind),
        .symbol          (symbol),
        .code_length     (code_length),
        .table_start     (table_start),
        .end_symbol_we   (end_symbol_we),
        .end_symbol_data (end_symbol_data),
        .valid           (valid),
        .out_byte        (out_byte),
        .is_last         (is_last),
        .error           (error)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    task automatic push_byte(input logic [BYTE_W-1:0] b, input logic lst, input logic er);
        packed_byte_t r;
        r.data = b;
        r.last = lst;
        r.err  = er;
        expected_bytes = {expected_bytes, r};
    endtask

    // shift code bits in msb first, a byte leaves as soon as it fills
    task automatic append_code(input logic [CODE_LEN_MAX-1:0] cw, input int n);
        for (int i = n; i > 0; i--)
        begin
            acc_bits = {acc_bits[BYTE_W-2:0], cw[i-1]};
            acc_count++;
            if (acc_count == BYTE_W)
            begin
                push_byte(acc_bits, 1'b0, 1'b0);
                acc_bits  = '0;
                acc_count = 0;
            end
        end
    endtask

    task automatic code_and_pack(input logic [KIND_W-1:0] k, input logic [SYM_W-1:0] sym,
                                 input logic [LEN_W-1:0] len_in, input logic ts);
        int               len;
        int               grow;
        int               queued;
        logic [63:0]      wide;
        logic [63:0]      mask;
        logic [SYM_W-1:0] s;
        if (k == KIND_LOAD)
        begin
            if (ts)
            begin
                for (int i = 0; i < SYMBOL_COUNT; i++)
                    present[i] = 1'b0;
                acc_bits    = '0;
                acc_count   = 0;
                first_entry = 1'b1;
            end
            len = (int'(len_in) > CODE_LEN_MAX) ? CODE_LEN_MAX : int'(len_in);
            if (first_entry)
            begin
                wide        = '0;
                first_entry = 1'b0;
            end
            else
            begin
                // a shorter length than the last entry adds no shift
                grow = (len > int'(last_len)) ? len - int'(last_len) : 0;
                wide = (64'(prev_code_word) + 64'd1) << grow;
            end
            mask           = (64'd1 << len) - 64'd1;
            prev_code_word = wide[CODE_LEN_MAX-1:0];
            last_len       = len[LEN_W-1:0];
            code_word[sym] = prev_code_word & mask[CODE_LEN_MAX-1:0];
            code_len[sym]  = len[LEN_W-1:0];
            present[sym]   = 1'b1;
        end
        else if (k == KIND_ENCODE || k == KIND_END)
        begin
            s = (k == KIND_ENCODE) ? sym : end_sym;
            if (!present[s])
                push_byte('0, 1'b0, 1'b1);
            else
            begin
                queued = expected_bytes.size();
                append_code(code_word[s], int'(code_len[s]));
                if (k == KIND_END)
                begin
                    if (acc_count != 0)
                    begin
                        push_byte(8'(acc_bits << (BYTE_W - acc_count)), 1'b0, 1'b0);
                        acc_bits  = '0;
                        acc_count = 0;
                    end
                    if (expected_bytes.size() > queued)
                        expected_bytes[expected_bytes.size()-1].last = 1'b1;
                end
            end
        end
    endtask

    task automatic pause_sender();
        int gap;
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 50)
            gap = 0;
        else if (r < 85)
            gap = $urandom_range(1, 3);
        else if (r < 97)
            gap = $urandom_range(4, 10);
        else
            gap = $urandom_range(20, 40);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_req(input logic [KIND_W-1:0] k, input logic [SYM_W-1:0] sym,
                            input logic [LEN_W-1:0] len, input logic ts);
        start       <= 1'b1;
        kind        <= k;
        symbol      <= sym;
        code_length <= len;
        table_start <= ts;
        do
            @(posedge clk);
        while (busy);
        code_and_pack(k, sym, len, ts);
        if (k != KIND_UNUSED)
            sent_items++;
        pause_sender();
    endtask

    task automatic drain();
        start <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge clk);
        // a load gives no byte but can still be running
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_end_symbol(input logic [SYM_W-1:0] v);
        drain();
        end_symbol_we   <= 1'b1;
        end_symbol_data <= v;
        @(posedge clk);
        end_symbol_we   <= 1'b0;
        end_sym = v;
    endtask

    task automatic test_empty_table();
        send_req(KIND_ENCODE, 7'd5, '0, 1'b0);
        send_req(KIND_END, '0, '0, 1'b0);
        send_req(KIND_UNUSED, 7'd127, 6'd63, 1'b1);
    endtask

    task automatic test_table_corners();
        send_req(KIND_LOAD, 7'd0, 6'd1, 1'b1);
        send_req(KIND_LOAD, 7'd3, 6'd2, 1'b0);
        send_req(KIND_LOAD, 7'd127, 6'd5, 1'b0);
        send_req(KIND_LOAD, 7'd64, 6'd63, 1'b0);  // saturates to the longest code
        send_req(KIND_LOAD, 7'd5, 6'd3, 1'b0);    // shorter: code is cut to its length
        send_req(KIND_LOAD, 7'd9, 6'd0, 1'b0);    // zero-length code
        send_req(KIND_LOAD, 7'd127, 6'd32, 1'b0); // reload overwrites
        send_req(KIND_ENCODE, 7'd0, 6'($urandom), 1'b0);
        send_req(KIND_ENCODE, 7'd3, 6'($urandom), 1'b1);
        send_req(KIND_ENCODE, 7'd127, 6'($urandom), 1'b0);
        send_req(KIND_ENCODE, 7'd64, 6'($urandom), 1'b0);
        send_req(KIND_ENCODE, 7'd5, 6'($urandom), 1'b0);
        send_req(KIND_ENCODE, 7'd9, 6'($urandom), 1'b0);
        send_req(KIND_ENCODE, 7'd1, 6'($urandom), 1'b0);
        send_req(KIND_END, 7'($urandom), 6'($urandom), 1'b1);
    endtask

    task automatic test_end_symbols();
        set_end_symbol(7'd9);
        send_req(KIND_END, '0, '0, 1'b0);    // nothing to flush
        set_end_symbol(7'd127);
        send_req(KIND_ENCODE, 7'd0, '0, 1'b0);
        send_req(KIND_END, '0, '0, 1'b0);
        set_end_symbol(7'd0);
        send_req(KIND_END, 7'd127, 6'd63, 1'b0);
        set_end_symbol(7'd100);
        send_req(KIND_END, '0, '0, 1'b0);    // unmapped terminator
    endtask

    task automatic test_random_streams();
        int               target;
        int               n_entries;
        int               n_msg;
        int               len;
        int               prev_len;
        int               tries;
        int               r;
        bit               broken;
        bit               used [SYMBOL_COUNT];
        logic [SYM_W-1:0] sym;
        logic [SYM_W-1:0] prev_sym;
        target = sent_items + RANDOM_ITEMS;
        while (sent_items < target)
        begin
            no_gaps = ($urandom_range(0, 3) == 0);
            broken  = ($urandom_range(0, 9) == 0);
            for (int i = 0; i < SYMBOL_COUNT; i++)
                used[i] = 1'b0;
            tbl_syms.delete();
            n_entries = $urandom_range(2, 16);
            len       = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 3);
            prev_len  = -1;
            prev_sym  = '0;
            // sorted by length then symbol, with the odd shrinking length
            for (int e = 0; e < n_entries; e++)
            begin
                if (e > 0)
                begin
                    r = $urandom_range(0, 99);
                    if (r >= 97)
                        len = $urandom_range(0, len);
                    else if (r >= 90)
                        len += $urandom_range(5, 12);
                    else if (r >= 52)
                        len += $urandom_range(1, 2);
                    if (len > 63)
                        len = 63;
                end
                tries = 0;
                do
                begin
                    sym = 7'($urandom_range(0, SYMBOL_COUNT - 1));
                    tries++;
                end
                while ((used[sym] || (len == prev_len && sym <= prev_sym)) && tries < 64);
                if (used[sym] || (len == prev_len && sym <= prev_sym))
                    continue;
                used[sym] = 1'b1;
                tbl_syms = {tbl_syms, sym};
                send_req(KIND_LOAD, sym, len[LEN_W-1:0], (tbl_syms.size() == 1) && !broken);
                prev_sym = sym;
                prev_len = len;
            end
            if ($urandom_range(0, 1) == 0)
            begin
                r = $urandom_range(0, 99);
                if (r < 75)
                    set_end_symbol(tbl_syms[$urandom_range(0, tbl_syms.size() - 1)]);
                else if (r < 85)
                    set_end_symbol('0);
                else if (r < 95)
                    set_end_symbol('1);
                else
                    set_end_symbol(7'($urandom));
            end
            n_msg = $urandom_range(1, 20);
            for (int m = 0; m < n_msg; m++)
            begin
                r = $urandom_range(0, 99);
                if (r < 88)
                    send_req(KIND_ENCODE, tbl_syms[$urandom_range(0, tbl_syms.size() - 1)],
                             6'($urandom), 1'($urandom));
                else if (r < 94)
                    send_req(KIND_ENCODE, 7'($urandom), 6'($urandom), 1'($urandom));
                else
                    send_req(KIND_UNUSED, 7'($urandom), 6'($urandom), 1'($urandom));
            end
            if ($urandom_range(0, 99) < 85)
                send_req(KIND_END, 7'($urandom), 6'($urandom), 1'($urandom));
        end
    endtask

    always @(posedge clk)
    begin
        packed_byte_t want;
        if (rst_n && valid)
        begin
            if (expected_bytes.size() == 0)
            begin
                $display("%0t: unexpected result byte %02h last %0b error %0b",
                         $time, out_byte, is_last, error);
                err_count++;
            end
            else
            begin
                want = expected_bytes.pop_front();
                if (out_byte !== want.data)
                begin
                    $display("%0t: out_byte expected %02h actual %02h", $time, want.data, out_byte);
                    err_count++;
                end
                if (is_last !== want.last)
                begin
                    $display("%0t: is_last expected %0b actual %0b", $time, want.last, is_last);
                    err_count++;
                end
                if (error !== want.err)
                begin
                    $display("%0t: error expected %0b actual %0b", $time, want.err, error);
                    err_count++;
                end
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (start && !busy) || valid)
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no request or result for %0d cycles", $time, STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_table();
        test_table_corners();
        test_end_symbols();
        test_random_streams();
        drain();
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
